@@ rtl/core/swm_pkg.sv @@
// Shared types and constants for the sliding-window median block.
// Used by every module under rtl/core; no dependencies.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int WINDOW_DEF      = 240;
    localparam int SAMPLE_BITS_DEF = 20;
    localparam int FILL_BITS       = 8;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RING_WR,
        S_FETCH,
        S_MERGE,
        S_MED_RD,
        S_MED_WAIT
    } t_state;

    // Enables of one memory port pair.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

@@ rtl/core/swm_ring_mem.sv @@
// Sample ring: WINDOW entries in arrival order, one write and one read port.
// Uses swm_pkg for the port enable struct.
`timescale 1ns / 1ps

module swm_ring_mem #(
    parameter int WINDOW      = swm_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic                   i_clk,
    input  swm_pkg::t_mem_ctl      i_ctl,
    input  logic [IDX_W-1:0]       i_waddr,
    input  logic [SAMPLE_BITS-1:0] i_wdata,
    input  logic [IDX_W-1:0]       i_raddr,
    output logic [SAMPLE_BITS-1:0] o_rdata
);

    logic [SAMPLE_BITS-1:0] r_mem [0:WINDOW-1];
    logic [SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/swm_sort_mem.sv @@
// Sorted copy of the window, two banks of WINDOW entries (read one, write other).
// Uses swm_pkg for the port enable struct.
`timescale 1ns / 1ps

module swm_sort_mem #(
    parameter int WINDOW      = swm_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    localparam int ADDR_W     = $clog2(2 * WINDOW)
) (
    input  logic                   i_clk,
    input  swm_pkg::t_mem_ctl      i_ctl,
    input  logic [ADDR_W-1:0]      i_waddr,
    input  logic [SAMPLE_BITS-1:0] i_wdata,
    input  logic [ADDR_W-1:0]      i_raddr,
    output logic [SAMPLE_BITS-1:0] o_rdata
);

    logic [SAMPLE_BITS-1:0] r_mem [0:2*WINDOW-1];
    logic [SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/swm_seq.sv @@
// Per-sample sequencer: ring update, merge of the sorted bank, median read.
// Uses swm_pkg (state enum, memory enable struct).
`timescale 1ns / 1ps

module swm_seq #(
    parameter int WINDOW      = swm_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    localparam int CNT_W      = $clog2(WINDOW + 1),
    localparam int ADDR_W     = $clog2(2 * WINDOW)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_busy,
    input  logic                   i_out_free,
    output logic                   o_done,
    output logic [CNT_W-1:0]       o_fill,
    output swm_pkg::t_mem_ctl      o_ring_ctl,
    output logic [IDX_W-1:0]       o_ring_waddr,
    output logic [IDX_W-1:0]       o_ring_raddr,
    output logic [SAMPLE_BITS-1:0] o_ring_wdata,
    input  logic [SAMPLE_BITS-1:0] i_ring_rdata,
    output swm_pkg::t_mem_ctl      o_sort_ctl,
    output logic [ADDR_W-1:0]      o_sort_waddr,
    output logic [ADDR_W-1:0]      o_sort_raddr,
    output logic [SAMPLE_BITS-1:0] o_sort_wdata,
    input  logic [SAMPLE_BITS-1:0] i_sort_rdata
);

    swm_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]       r_held, n_held;
    logic [IDX_W-1:0]       r_oldest, n_oldest;
    logic                   r_bank, n_bank;
    logic                   r_full, n_full;
    logic [CNT_W-1:0]       r_m, n_m;
    logic [CNT_W-1:0]       r_n_new, n_n_new;
    logic [CNT_W-1:0]       r_rd, n_rd;
    logic [CNT_W-1:0]       r_wr, n_wr;
    logic                   r_ins_done, n_ins_done;
    logic                   r_del_done, n_del_done;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;

    logic x_valid;

    function automatic logic [ADDR_W-1:0] sort_addr(input logic bank,
                                                    input logic [CNT_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(idx);
        return bank ? base + ADDR_W'(WINDOW) : base;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= swm_pkg::S_IDLE;
            r_held     <= '0;
            r_oldest   <= '0;
            r_bank     <= 1'b0;
            r_full     <= 1'b0;
            r_m        <= '0;
            r_n_new    <= '0;
            r_rd       <= '0;
            r_wr       <= '0;
            r_ins_done <= 1'b0;
            r_del_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_held     <= n_held;
            r_oldest   <= n_oldest;
            r_bank     <= n_bank;
            r_full     <= n_full;
            r_m        <= n_m;
            r_n_new    <= n_n_new;
            r_rd       <= n_rd;
            r_wr       <= n_wr;
            r_ins_done <= n_ins_done;
            r_del_done <= n_del_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
    end

    assign x_valid = (r_rd < r_m);

    always_comb begin
        n_state      = r_state;
        n_held       = r_held;
        n_oldest     = r_oldest;
        n_bank       = r_bank;
        n_full       = r_full;
        n_m          = r_m;
        n_n_new      = r_n_new;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_ins_done   = r_ins_done;
        n_del_done   = r_del_done;
        n_sample     = r_sample;
        o_busy       = 1'b1;
        o_done       = 1'b0;
        o_ring_ctl   = '0;
        o_ring_raddr = r_oldest;
        o_ring_waddr = r_full ? r_oldest : r_m[IDX_W-1:0];
        o_ring_wdata = r_sample;
        o_sort_ctl   = '0;
        o_sort_raddr = sort_addr(r_bank, r_rd);
        o_sort_waddr = sort_addr(!r_bank, r_wr);
        o_sort_wdata = r_sample;

        case (r_state)
            swm_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    // Fetch the entry about to be overwritten; unused while filling.
                    o_ring_ctl.rd_en = (r_held == CNT_W'(WINDOW));
                    n_sample   = i_sample;
                    n_full     = (r_held == CNT_W'(WINDOW));
                    n_m        = r_held;
                    n_n_new    = (r_held == CNT_W'(WINDOW)) ? r_held : r_held + 1'b1;
                    n_rd       = '0;
                    n_wr       = '0;
                    n_ins_done = 1'b0;
                    n_del_done = 1'b0;
                    n_state    = swm_pkg::S_RING_WR;
                end
            end
            swm_pkg::S_RING_WR: begin
                o_ring_ctl.wr_en = 1'b1;
                if (r_full) begin
                    n_oldest = (r_oldest == IDX_W'(WINDOW - 1)) ? '0 : r_oldest + 1'b1;
                end else begin
                    n_held = r_held + 1'b1;
                end
                n_state = swm_pkg::S_FETCH;
            end
            swm_pkg::S_FETCH: begin
                o_sort_ctl.rd_en = x_valid;
                n_state = swm_pkg::S_MERGE;
            end
            swm_pkg::S_MERGE: begin
                if (r_full && !r_del_done && x_valid && (i_sort_rdata == i_ring_rdata)) begin
                    // Drop the evicted sample once.
                    n_del_done = 1'b1;
                    n_rd       = r_rd + 1'b1;
                end else if (!r_ins_done && (!x_valid || (r_sample <= i_sort_rdata))) begin
                    o_sort_ctl.wr_en = 1'b1;
                    o_sort_wdata     = r_sample;
                    n_ins_done       = 1'b1;
                    n_wr             = r_wr + 1'b1;
                end else begin
                    o_sort_ctl.wr_en = 1'b1;
                    o_sort_wdata     = i_sort_rdata;
                    n_wr             = r_wr + 1'b1;
                    n_rd             = r_rd + 1'b1;
                end
                n_state = (n_wr == r_n_new) ? swm_pkg::S_MED_RD : swm_pkg::S_FETCH;
            end
            swm_pkg::S_MED_RD: begin
                o_sort_ctl.rd_en = 1'b1;
                o_sort_raddr     = sort_addr(!r_bank, r_n_new >> 1);
                n_bank           = !r_bank;
                n_state          = swm_pkg::S_MED_WAIT;
            end
            swm_pkg::S_MED_WAIT: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = swm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swm_pkg::S_IDLE;
            end
        endcase
    end

    assign o_fill = r_n_new;

endmodule

@@ rtl/core/sliding_window_median.sv @@
// Top level of the sliding-window median: sequencer, two memories, result register.
// Depends on swm_pkg, swm_ring_mem, swm_sort_mem and swm_seq.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   sample  | in        | i_valid / o_stall    | i_sample_us
//   result  | out       | o_valid / i_stall    | o_median_us, o_fill_count
//
// Steps: one sample takes s merge steps with s <= n + 1, n being the fill count
// after the sample. Each merge step is one read of the single read port of the
// sorted memory, then one compare and at most one write.
// Reset: synchronous, active low; clears the fill count, ring pointer and bank
// select. Memory contents are not cleared; only written entries are ever read.
// Stalls: o_stall is high while a sample is in work; a finished result waits in
// the output register, and the sequencer holds its last step if that is still full.
`timescale 1ns / 1ps

module sliding_window_median #(
    parameter int WINDOW      = swm_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [SAMPLE_BITS-1:0]        i_sample_us,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [SAMPLE_BITS-1:0]        o_median_us,
    output logic [swm_pkg::FILL_BITS-1:0] o_fill_count
);

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int ADDR_W = $clog2(2 * WINDOW);

    // Sequencer <-> memories
    swm_pkg::t_mem_ctl      ring_ctl, sort_ctl;
    logic [IDX_W-1:0]       ring_waddr, ring_raddr;
    logic [SAMPLE_BITS-1:0] ring_wdata, ring_rdata;
    logic [ADDR_W-1:0]      sort_waddr, sort_raddr;
    logic [SAMPLE_BITS-1:0] sort_wdata, sort_rdata;

    logic             seq_busy;
    logic             seq_done;
    logic [CNT_W-1:0] seq_fill;
    logic             out_free;

    // Result register
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_median;
    logic [CNT_W-1:0]       r_fill;

    // The result slot can take a new transaction when empty or being drained now.
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = seq_busy;

    swm_seq #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_valid),
        .i_sample     (i_sample_us),
        .o_busy       (seq_busy),
        .i_out_free   (out_free),
        .o_done       (seq_done),
        .o_fill       (seq_fill),
        .o_ring_ctl   (ring_ctl),
        .o_ring_waddr (ring_waddr),
        .o_ring_raddr (ring_raddr),
        .o_ring_wdata (ring_wdata),
        .i_ring_rdata (ring_rdata),
        .o_sort_ctl   (sort_ctl),
        .o_sort_waddr (sort_waddr),
        .o_sort_raddr (sort_raddr),
        .o_sort_wdata (sort_wdata),
        .i_sort_rdata (sort_rdata)
    );

    swm_ring_mem #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_ctl   (ring_ctl),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    swm_sort_mem #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sort (
        .i_clk   (i_clk),
        .i_ctl   (sort_ctl),
        .i_waddr (sort_waddr),
        .i_wdata (sort_wdata),
        .i_raddr (sort_raddr),
        .o_rdata (sort_rdata)
    );

    // Hold the result until taken; load a new one when the sequencer finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_median <= sort_rdata;
            r_fill   <= seq_fill;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_median_us  = r_median;
    assign o_fill_count = swm_pkg::FILL_BITS'(r_fill);

endmodule

@@ rtl/core/swm_checker.sv @@
// Port-level checks for sliding_window_median, attached by bind.
// Depends on swm_pkg and the top level's port list.
`timescale 1ns / 1ps

module swm_checker #(
    parameter int WINDOW      = swm_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [SAMPLE_BITS-1:0]        o_median_us,
    input logic [swm_pkg::FILL_BITS-1:0] o_fill_count
);

    // A taken sample keeps the input stalled while it is in work.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepting a sample");

    // A result never reports an empty window.
    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (WINDOW < 256)) |-> (o_fill_count != '0))
        else $error("result with zero fill count");

    // The fill count never exceeds the window.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((WINDOW > 255) || (o_fill_count <= swm_pkg::FILL_BITS'(WINDOW))))
        else $error("fill count beyond window");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_median_us) && $stable(o_fill_count)))
        else $error("stalled result changed");

endmodule

bind sliding_window_median swm_checker #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_median: streams frame durations,
// predicts the windowed upper median in place and checks every result transaction.
// Depends on swm_pkg and the sliding_window_median RTL.

module tb_top;

    localparam int WIN = swm_pkg::WINDOW_DEF;
    localparam int SB  = swm_pkg::SAMPLE_BITS_DEF;
    localparam int FB  = swm_pkg::FILL_BITS;

    localparam logic [SB-1:0] SAMPLE_MAX = '1;

    // Give the tail comfortable slack beyond what one sample can cost.
    localparam int DRAIN_CYCLES = 2 * WIN + 100;

    // Receiver hold-off long enough to back the block up into its input.
    localparam int LONG_HOLD_CYCLES = 2500;

    typedef struct packed {
        logic [SB-1:0] median_us;
        logic [FB-1:0] fill_count;
    } t_median_result;

    // Block ports, every input known from time zero.
    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_valid     = 1'b0;
    logic [SB-1:0] i_sample_us = '0;
    logic          i_stall     = 1'b0;
    logic          o_stall;
    logic          o_valid;
    logic [SB-1:0] o_median_us;
    logic [FB-1:0] o_fill_count;

    sliding_window_median uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample_us  (i_sample_us),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_median_us  (o_median_us),
        .o_fill_count (o_fill_count)
    );

    // Traffic shaping knobs, written by the stimulus process after a rising edge
    // and read by the driver and the receiver at the falling edge.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;

    logic [SB-1:0] pending_samples [$];
    int            samples_queued = 0;
    int            samples_taken  = 0;
    bit            sample_taken   = 1'b0;
    int            fail_count     = 0;

    // Window model: ring of the last WIN samples, fill count and oldest slot.
    logic [SB-1:0]  window_ring [WIN];
    int unsigned    held_n     = 0;
    int unsigned    oldest_idx = 0;
    t_median_result median_expected [$];

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Store one accepted sample in the window and queue the median it yields.
    function automatic void push_window_sample(input logic [SB-1:0] sample);
        logic [SB-1:0]  ranked [WIN];
        logic [SB-1:0]  key;
        int             j;
        t_median_result res;
        if (held_n < WIN) begin
            window_ring[held_n] = sample;
            held_n++;
        end else begin
            window_ring[oldest_idx] = sample;
            oldest_idx = (oldest_idx + 1 == WIN) ? 0 : oldest_idx + 1;
        end
        // Insertion sort of the held entries; duplicates keep separate ranks.
        for (int i = 0; i < held_n; i++) begin
            key = window_ring[i];
            j   = i;
            while (j > 0 && ranked[j-1] > key) begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = key;
        end
        // Rank floor(n/2) from zero: the upper median for even n.
        res.median_us  = ranked[held_n / 2];
        res.fill_count = FB'(held_n);
        median_expected.push_back(res);
    endfunction

    // Driver: advance to the next pending sample once the current transaction
    // is taken, idling at random; hold the payload while the block stalls.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || sample_taken)) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid     <= 1'b1;
                i_sample_us <= pending_samples.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, or hold off for a counted stretch on request.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: predict on every accepted sample, then check every accepted result
    // against the oldest prediction still waiting.
    always @(posedge i_clk) begin : check_results
        t_median_result want;
        if (!i_rst_n) begin
            sample_taken <= 1'b0;
        end else begin
            sample_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                push_window_sample(i_sample_us);
                samples_taken <= samples_taken + 1;
            end
            if (o_valid && !i_stall) begin
                if (median_expected.size() == 0) begin
                    $error("result with nothing expected: median_us=%0d fill_count=%0d",
                           o_median_us, o_fill_count);
                    fail_count++;
                end else begin
                    want = median_expected.pop_front();
                    if (o_median_us !== want.median_us) begin
                        $error("median_us mismatch: expected %0d, got %0d",
                               want.median_us, o_median_us);
                        fail_count++;
                    end
                    if (o_fill_count !== want.fill_count) begin
                        $error("fill_count mismatch: expected %0d, got %0d",
                               want.fill_count, o_fill_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic queue_sample(input logic [SB-1:0] sample);
        pending_samples.push_back(sample);
        samples_queued++;
    endtask

    // Queue bursts of samples, each burst drawn from one value profile: full
    // range, typical frame times, few distinct values, extremes, and ramps that
    // push new samples steadily to one end of the sorted order.
    task automatic queue_random_batch(input int count);
        int            profile;
        int            run;
        logic [SB-1:0] level;
        logic [SB-1:0] sample;
        level = SB'($urandom);
        while (count > 0) begin
            profile = $urandom_range(7);
            run     = $urandom_range(1, 40);
            for (int k = 0; k < run && count > 0; k++) begin
                case (profile)
                    1: sample = SB'(11667 + $urandom_range(10000));
                    2: sample = SB'($urandom_range(7) * 1024);
                    3: begin
                        case ($urandom_range(3))
                            0: sample = '0;
                            1: sample = SB'(1);
                            2: sample = SAMPLE_MAX - 1'b1;
                            default: sample = SAMPLE_MAX;
                        endcase
                    end
                    4: begin
                        level  = (level > SAMPLE_MAX - 4096) ? SAMPLE_MAX
                                                             : level + SB'($urandom_range(4095));
                        sample = level;
                    end
                    5: begin
                        level  = (level < 4096) ? '0 : level - SB'($urandom_range(4095));
                        sample = level;
                    end
                    default: sample = SB'($urandom);
                endcase
                queue_sample(sample);
                count--;
            end
        end
    endtask

    // Poll at the falling edge, where the monitor's counters are settled, and
    // return aligned to a rising edge so the knobs change away from the driver.
    task automatic wait_samples_taken;
        do @(negedge i_clk); while (samples_taken != samples_queued);
        @(posedge i_clk);
    endtask

    task automatic wait_results_drained;
        do @(negedge i_clk); while (median_expected.size() != 0);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        // Opening samples: first sample alone, extremes, duplicates, bit patterns.
        logic [SB-1:0] opening [17] = '{
            SAMPLE_MAX, '0, '0, SAMPLE_MAX, SAMPLE_MAX, SB'(1), SAMPLE_MAX - 1'b1,
            SB'(20'h55555), SB'(20'hAAAAA), SB'(20'h80000), SB'(20'h7FFFF),
            SB'(16667), SB'(16667), SB'(16667), '0, SAMPLE_MAX, SB'(16667)
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: sender idles lightly, receiver stalls heavily.
        send_idle_pct = 23;
        recv_idle_pct = 57;
        foreach (opening[i]) queue_sample(opening[i]);
        queue_random_batch(370);
        wait_samples_taken();

        // Back the block up: hold the receiver off while samples keep coming.
        send_idle_pct = 0;
        hold_request  = LONG_HOLD_CYCLES;
        queue_random_batch(30);
        wait_samples_taken();

        // Pause the sender until every expected result has come out.
        wait_results_drained();

        // Phase two: roles swapped.
        send_idle_pct = 57;
        recv_idle_pct = 23;
        queue_random_batch(370);
        wait_samples_taken();

        // Phase three: full speed on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_batch(380);
        wait_samples_taken();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: a correct run of under 1.2k samples at an 8 ns clock plus the long
    // hold-off needs about 6 ms; allow several times that.
    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ sliding_window_median.f @@
rtl/core/swm_pkg.sv
rtl/core/swm_ring_mem.sv
rtl/core/swm_sort_mem.sv
rtl/core/swm_seq.sv
rtl/core/sliding_window_median.sv
rtl/core/swm_checker.sv
tb/sv/tb_top.sv
